### hw/rtl/xome_pkg.sv
// Package for the x86 opcode / ModRM encoder: descriptor and queue status types,
// prefix and ModRM constants. No dependencies.
`default_nettype none

package xome_pkg;

   localparam int unsigned MAX_BYTES  = 9;
   localparam int unsigned BYTE_IDX_W = 4;

   // operand size codes
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;
   localparam logic [1:0] SIZE_QWORD = 2'd3;

   localparam logic [7:0] PREFIX_WORD  = 8'h66;
   localparam logic [7:0] PREFIX_QWORD = 8'h48;

   // ModRM mod field codes
   localparam logic [1:0] MOD_NODISP = 2'b00;
   localparam logic [1:0] MOD_DISP8  = 2'b01;
   localparam logic [1:0] MOD_DISP32 = 2'b10;
   localparam logic [1:0] MOD_REG    = 2'b11;

   localparam logic [2:0] REG_SP    = 3'd4;
   localparam logic [2:0] REG_BP    = 3'd5;
   localparam logic [2:0] RM_SIB    = 3'd4;
   localparam logic [2:0] RM_DISP32 = 3'd5;

   // SIB: no index, base SP
   localparam logic [7:0] SIB_SP_BASE = {2'b00, REG_SP, REG_SP};

   // One fully encoded instruction, as handed from front to back
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [BYTE_IDX_W-1:0]     count;
      logic [BYTE_IDX_W-1:0]     reloc_idx;
      logic                      reloc_en;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

### hw/rtl/xome_front.sv
// Front end: takes a request, encodes it into a byte descriptor and holds it
// until the queue has room. Depends on xome_pkg.
`default_nettype none

module xome_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [15:0]          req_opcode,
   input  wire logic [1:0]           req_operand_size,
   input  wire logic [2:0]           req_reg_field,
   input  wire logic                 req_register_direct,
   input  wire logic [2:0]           req_base_reg,
   input  wire logic                 req_has_label,
   input  wire logic signed [31:0]   req_displacement,
   input  wire logic                 queue_full,
   output logic                      push,
   output xome_pkg::desc_type        push_desc
);

   xome_pkg::desc_type desc_ff, desc_in;
   logic               vld_ff, vld_in;
   logic               load;
   logic               accept;

   logic [xome_pkg::BYTE_IDX_W-1:0] n;
   logic [1:0]  mod;
   logic [2:0]  rm;
   logic        use_sib;
   logic [2:0]  disp_len;
   logic        disp_zero;
   logic        disp_short;
   logic [31:0] disp_u;

   assign load   = !vld_ff || !queue_full;
   assign busy   = !load;
   assign accept = start && load;
   assign push   = vld_ff && !queue_full;
   assign push_desc = desc_ff;

   // encode
   always_comb begin
      desc_in    = '0;
      n          = '0;
      disp_u     = req_displacement;
      disp_zero  = (disp_u == 32'd0);
      // fits disp8 when bits 31..7 are all equal
      disp_short = (disp_u[31:7] == '0) || (disp_u[31:7] == '1);

      if (req_register_direct) begin
         mod = xome_pkg::MOD_REG;
      end else if (req_has_label) begin
         mod = xome_pkg::MOD_NODISP;
      end else if (disp_zero && req_base_reg != xome_pkg::REG_BP) begin
         mod = xome_pkg::MOD_NODISP;
      end else if (disp_short) begin
         mod = xome_pkg::MOD_DISP8;
      end else begin
         mod = xome_pkg::MOD_DISP32;
      end

      use_sib = !req_register_direct && !req_has_label && req_base_reg == xome_pkg::REG_SP;

      if (!req_register_direct && req_has_label) begin
         rm = xome_pkg::RM_DISP32;
      end else if (use_sib) begin
         rm = xome_pkg::RM_SIB;
      end else begin
         rm = req_base_reg;
      end

      if (mod == xome_pkg::MOD_DISP8) begin
         disp_len = 3'd1;
      end else if (mod == xome_pkg::MOD_DISP32 ||
                   (!req_register_direct && req_has_label)) begin
         disp_len = 3'd4;
      end else begin
         disp_len = 3'd0;
      end

      if (req_operand_size == xome_pkg::SIZE_WORD) begin
         desc_in.bytes[n] = xome_pkg::PREFIX_WORD;
         n = n + 1'b1;
      end else if (req_operand_size == xome_pkg::SIZE_QWORD) begin
         desc_in.bytes[n] = xome_pkg::PREFIX_QWORD;
         n = n + 1'b1;
      end
      if (req_opcode[15:8] != 8'd0) begin
         desc_in.bytes[n] = req_opcode[15:8];
         n = n + 1'b1;
      end
      desc_in.bytes[n] = req_opcode[7:0] |
                         {7'd0, req_operand_size != xome_pkg::SIZE_BYTE};
      n = n + 1'b1;
      desc_in.bytes[n] = {mod, req_reg_field, rm};
      n = n + 1'b1;
      if (use_sib) begin
         desc_in.bytes[n] = xome_pkg::SIB_SP_BASE;
         n = n + 1'b1;
      end
      desc_in.reloc_idx = n;
      desc_in.reloc_en  = !req_register_direct && req_has_label;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < disp_len) begin
            desc_in.bytes[n] = disp_u[8*k +: 8];
            n = n + 1'b1;
         end
      end
      desc_in.count = n;
   end

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/xome_queue.sv
// Descriptor queue between front and back ends (registered entries).
// Depends on xome_pkg.
`default_nettype none

module xome_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire xome_pkg::desc_type     push_desc,
   input  wire logic                   pop,
   output xome_pkg::desc_type          head_desc,
   output xome_pkg::queue_status_type  status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   xome_pkg::desc_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_desc    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/xome_back.sv
// Back end: walks the head descriptor one byte per cycle onto registered
// result ports and retires it after its last byte. Depends on xome_pkg.
`default_nettype none

module xome_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire xome_pkg::desc_type     head_desc,
   input  wire xome_pkg::queue_status_type status,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_reloc_start,
   output logic                        rsp_last
);

   logic [xome_pkg::BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic       emit;
   logic       at_last;
   logic       strobe_ff, strobe_in;
   logic [7:0] byte_ff, byte_in;
   logic       reloc_ff, reloc_in;
   logic       last_ff, last_in;

   assign emit    = !status.empty;
   assign at_last = (idx_ff == head_desc.count - 1'b1);
   assign pop     = emit && at_last;

   always_comb begin
      strobe_in = emit;
      byte_in   = head_desc.bytes[idx_ff];
      reloc_in  = emit && head_desc.reloc_en && (idx_ff == head_desc.reloc_idx);
      last_in   = emit && at_last;
      if (!emit) begin
         idx_in = idx_ff;
      end else if (at_last) begin
         idx_in = '0;
      end else begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
         reloc_ff  <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
         reloc_ff  <= reloc_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_reloc_start = reloc_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

### hw/rtl/x86_opcode_modrm_encoder.sv
// Top level of the x86 opcode / ModRM / SIB encoder.
// Instantiates xome_front, xome_queue and xome_back; uses xome_pkg.
//
// Usage:
//  - Request channel: drive req_* and raise start; the request transfers at a
//    rising edge where start is high and busy is low.
//  - Result channel: one instruction byte per cycle on rsp_out_byte, marked by
//    rsp_strobe for exactly one cycle. rsp_last flags the final byte,
//    rsp_reloc_start the first byte of a label disp32. The receiver cannot
//    hold results off; it must take every strobed byte.
//  - An instruction is 2 to 9 bytes: optional 0x66/0x48 prefix, one or two
//    opcode bytes, ModRM, optional SIB, optional disp8/disp32.
//  - Path: the first byte passes the front register, the queue and the output
//    register; it waits in the front register while the queue is full.
//  - Throughput: the back end emits one byte per cycle while the queue is not
//    empty, finishing each item before the next. Back-to-back items stream
//    with no gap; the front accepts a new request every cycle while the queue
//    and front register have room, raising busy only when both are full.
//  - Reset (synchronous, active high) empties the front register and queue
//    and drops any partly emitted instruction.
`default_nettype none

module x86_opcode_modrm_encoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [15:0]          req_opcode,
   input  wire logic [1:0]           req_operand_size,
   input  wire logic [2:0]           req_reg_field,
   input  wire logic                 req_register_direct,
   input  wire logic [2:0]           req_base_reg,
   input  wire logic                 req_has_label,
   input  wire logic signed [31:0]   req_displacement,
   output logic                      rsp_strobe,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_reloc_start,
   output logic                      rsp_last
);

   logic                       push;
   xome_pkg::desc_type         push_desc;
   logic                       pop;
   xome_pkg::desc_type         head_desc;
   xome_pkg::queue_status_type queue_status;

   // front: encode the request into a byte descriptor
   xome_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_operand_size    (req_operand_size),
      .req_reg_field       (req_reg_field),
      .req_register_direct (req_register_direct),
      .req_base_reg        (req_base_reg),
      .req_has_label       (req_has_label),
      .req_displacement    (req_displacement),
      .queue_full          (queue_status.full),
      .push                (push),
      .push_desc           (push_desc)
   );

   // decouples encoding from byte emission
   xome_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .status    (queue_status)
   );

   // back: serialize bytes
   xome_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_desc       (head_desc),
      .status          (queue_status),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_reloc_start (rsp_reloc_start),
      .rsp_last        (rsp_last)
   );

   // a reloc byte opens a dword, so it is never last and the next byte follows
   a_reloc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_reloc_start |-> !rsp_last)
      else $error("reloc_start on last byte");

   a_reloc_followed: assert property (@(posedge clock) disable iff (reset)
      rsp_reloc_start |=> rsp_strobe && !rsp_last)
      else $error("displacement byte missing after reloc_start");

   // busy can only assert after a request was taken into the front register
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a transfer");

endmodule

`default_nettype wire

### dv/xome_checker.sv
`timescale 1ns / 100ps
// Scoreboard for x86_opcode_modrm_encoder: predicts the byte stream of every
// request transfer and compares it with the strobed bytes. Uses xome_pkg.
module xome_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [15:0]        req_opcode,
   input  wire logic [1:0]         req_operand_size,
   input  wire logic [2:0]         req_reg_field,
   input  wire logic               req_register_direct,
   input  wire logic [2:0]         req_base_reg,
   input  wire logic               req_has_label,
   input  wire logic signed [31:0] req_displacement,
   input  wire logic               rsp_strobe,
   input  wire logic [7:0]         rsp_out_byte,
   input  wire logic               rsp_reloc_start,
   input  wire logic               rsp_last,
   output int                      fail_count,
   output int                      bytes_pending,
   output int                      bytes_checked,
   output int                      reloc_bytes
);

   typedef struct packed {
      logic [7:0] value;
      logic       reloc;
      logic       last;
   } insn_byte_type;

   insn_byte_type insn_bytes_due[$];
   int            n_fail    = 0;
   int            n_checked = 0;
   int            n_reloc   = 0;

   initial begin
      fail_count    = 0;
      bytes_pending = 0;
      bytes_checked = 0;
      reloc_bytes   = 0;
   end

   function automatic void push_byte(input logic [7:0] value, input logic reloc);
      insn_byte_type b;
      b.value = value;
      b.reloc = reloc;
      b.last  = 1'b0;
      insn_bytes_due = {insn_bytes_due, b};
   endfunction

   // little-endian dword, relocation mark on the low byte only
   function automatic void push_dword(input logic [31:0] value, input logic reloc);
      push_byte(value[7:0], reloc);
      push_byte(value[15:8], 1'b0);
      push_byte(value[23:16], 1'b0);
      push_byte(value[31:24], 1'b0);
   endfunction

   // Expected encoding of one instruction, appended to the due list
   function automatic void encode_insn(
      input logic [15:0]        opc,
      input logic [1:0]         size,
      input logic [2:0]         rf,
      input logic               direct,
      input logic [2:0]         base,
      input logic               label,
      input logic signed [31:0] disp
   );
      logic [1:0] mode;
      logic [2:0] rm;
      if (size == xome_pkg::SIZE_WORD)
         push_byte(xome_pkg::PREFIX_WORD, 1'b0);
      else if (size == xome_pkg::SIZE_QWORD)
         push_byte(xome_pkg::PREFIX_QWORD, 1'b0);
      if (opc > 16'h00FF)
         push_byte(opc[15:8], 1'b0);
      push_byte({opc[7:1], opc[0] | (size != xome_pkg::SIZE_BYTE)}, 1'b0);

      if (direct) begin
         // register form wins over any label
         push_byte({xome_pkg::MOD_REG, rf, base}, 1'b0);
      end else if (label) begin
         push_byte({xome_pkg::MOD_NODISP, rf, xome_pkg::RM_DISP32}, 1'b0);
         push_dword(disp, 1'b1);
      end else begin
         // BP base has no mod 00 form: zero offset goes out as disp8 0
         if (disp == 0 && base != xome_pkg::REG_BP)
            mode = xome_pkg::MOD_NODISP;
         else if (disp >= -128 && disp <= 127)
            mode = xome_pkg::MOD_DISP8;
         else
            mode = xome_pkg::MOD_DISP32;
         rm = (base == xome_pkg::REG_SP) ? xome_pkg::RM_SIB : base;
         push_byte({mode, rf, rm}, 1'b0);
         if (base == xome_pkg::REG_SP)
            push_byte(xome_pkg::SIB_SP_BASE, 1'b0);
         if (mode == xome_pkg::MOD_DISP8)
            push_byte(disp[7:0], 1'b0);
         else if (mode == xome_pkg::MOD_DISP32)
            push_dword(disp, 1'b0);
      end
      insn_bytes_due[insn_bytes_due.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      insn_byte_type want;
      if (reset) begin
         insn_bytes_due.delete();
      end else begin
         if (rsp_strobe) begin
            n_checked++;
            if (rsp_reloc_start)
               n_reloc++;
            if (insn_bytes_due.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("%0t: unexpected byte %02h reloc %0b last %0b", $realtime,
                           rsp_out_byte, rsp_reloc_start, rsp_last);
            end else begin
               want = insn_bytes_due.pop_front();
               if (rsp_out_byte !== want.value || rsp_reloc_start !== want.reloc ||
                   rsp_last !== want.last) begin
                  n_fail++;
                  if (n_fail <= 10)
                     $display("%0t: byte mismatch exp %02h/%0b/%0b got %02h/%0b/%0b",
                              $realtime, want.value, want.reloc, want.last,
                              rsp_out_byte, rsp_reloc_start, rsp_last);
               end
            end
         end
         if (start && !busy)
            encode_insn(req_opcode, req_operand_size, req_reg_field, req_register_direct,
                        req_base_reg, req_has_label, req_displacement);
      end
      fail_count    <= n_fail;
      bytes_pending <= insn_bytes_due.size();
      bytes_checked <= n_checked;
      reloc_bytes   <= n_reloc;
   end

endmodule

### dv/x86_opcode_modrm_encoder_tb.sv
`timescale 1ns / 100ps
// Top of the x86_opcode_modrm_encoder testbench: clock, reset, request stimulus
// and verdict. Needs xome_pkg, the encoder RTL and dv/xome_checker.sv.
module x86_opcode_modrm_encoder_tb;

   localparam int RANDOM_ITEMS = 420;

   typedef struct packed {
      logic [15:0]        opcode;
      logic [1:0]         size;
      logic [2:0]         reg_field;
      logic               direct;
      logic [2:0]         base;
      logic               label;
      logic signed [31:0] disp;
   } insn_req_type;

   logic               clock               = 1'b0;
   logic               reset               = 1'b1;
   logic               start               = 1'b0;
   logic [15:0]        req_opcode          = '0;
   logic [1:0]         req_operand_size    = xome_pkg::SIZE_BYTE;
   logic [2:0]         req_reg_field       = '0;
   logic               req_register_direct = 1'b0;
   logic [2:0]         req_base_reg        = '0;
   logic               req_has_label       = 1'b0;
   logic signed [31:0] req_displacement    = '0;

   wire                busy;
   wire                rsp_strobe;
   wire  [7:0]         rsp_out_byte;
   wire                rsp_reloc_start;
   wire                rsp_last;

   int fail_count;
   int bytes_pending;
   int bytes_checked;
   int reloc_bytes;
   int reqs_sent  = 0;
   int burst_left = 0;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   x86_opcode_modrm_encoder u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_operand_size    (req_operand_size),
      .req_reg_field       (req_reg_field),
      .req_register_direct (req_register_direct),
      .req_base_reg        (req_base_reg),
      .req_has_label       (req_has_label),
      .req_displacement    (req_displacement),
      .rsp_strobe          (rsp_strobe),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_reloc_start     (rsp_reloc_start),
      .rsp_last            (rsp_last)
   );

   xome_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_operand_size    (req_operand_size),
      .req_reg_field       (req_reg_field),
      .req_register_direct (req_register_direct),
      .req_base_reg        (req_base_reg),
      .req_has_label       (req_has_label),
      .req_displacement    (req_displacement),
      .rsp_strobe          (rsp_strobe),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_reloc_start     (rsp_reloc_start),
      .rsp_last            (rsp_last),
      .fail_count          (fail_count),
      .bytes_pending       (bytes_pending),
      .bytes_checked       (bytes_checked),
      .reloc_bytes         (reloc_bytes)
   );

   function automatic insn_req_type mk_req(
      input logic [15:0] opc, input logic [1:0] size, input logic [2:0] rf,
      input logic direct, input logic [2:0] base, input logic label,
      input logic signed [31:0] disp
   );
      insn_req_type r;
      r = '{opcode: opc, size: size, reg_field: rf, direct: direct, base: base,
            label: label, disp: disp};
      return r;
   endfunction

   // Mostly well-formed memory operands, biased to SP/BP bases and to the
   // disp8/disp32 boundaries; full-range values keep every bit toggling.
   function automatic insn_req_type rand_req();
      insn_req_type r;
      r.opcode    = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 255))
                                                : 16'($urandom);
      r.size      = 2'($urandom_range(0, 3));
      r.reg_field = 3'($urandom);
      r.direct    = ($urandom_range(0, 3) == 0);
      r.label     = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
         0:       r.base = xome_pkg::REG_SP;
         1:       r.base = xome_pkg::REG_BP;
         default: r.base = 3'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: r.disp = 0;
         1: r.disp = int'($urandom_range(0, 255)) - 128;
         2: begin
            case ($urandom_range(0, 3))
               0:       r.disp = 127;
               1:       r.disp = 128;
               2:       r.disp = -128;
               default: r.disp = -129;
            endcase
         end
         default: r.disp = $urandom;
      endcase
      return r;
   endfunction

   // Sender: bursts of back-to-back transfers, random idle gaps in between.
   // Opcode and displacement carry junk while start is low; the block must ignore it.
   task automatic issue(input insn_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0)
            start <= 1'b0;
         repeat (gap) begin
            req_opcode       <= 16'($urandom);
            req_displacement <= $urandom;
            @(posedge clock);
         end
      end
      burst_left--;
      req_opcode          <= r.opcode;
      req_operand_size    <= r.size;
      req_reg_field       <= r.reg_field;
      req_register_direct <= r.direct;
      req_base_reg        <= r.base;
      req_has_label       <= r.label;
      req_displacement    <= r.disp;
      start               <= 1'b1;
      // busy seen here is the pre-edge value: the transfer took place if low
      do @(posedge clock); while (busy);
      reqs_sent++;
   endtask

   initial begin
      insn_req_type directed[$];
      int           n_directed;

      // register forms; direct wins over label
      directed = {directed, mk_req(16'h0000, xome_pkg::SIZE_BYTE,  3'd0, 1'b1, 3'd0,
                                   1'b0, 0)};
      directed = {directed, mk_req(16'hFFFF, xome_pkg::SIZE_QWORD, 3'd7, 1'b1, 3'd7,
                                   1'b1, -1)};
      directed = {directed, mk_req(16'h00FF, xome_pkg::SIZE_WORD,  3'd5, 1'b1,
                                   xome_pkg::REG_SP, 1'b0, 0)};
      directed = {directed, mk_req(16'h0100, xome_pkg::SIZE_DWORD, 3'd2, 1'b1,
                                   xome_pkg::REG_BP, 1'b0, 0)};
      // zero offset, SP base with SIB, BP base forced to disp8 0
      directed = {directed, mk_req(16'h0089, xome_pkg::SIZE_DWORD, 3'd1, 1'b0, 3'd0,
                                   1'b0, 0)};
      directed = {directed, mk_req(16'h0F10, xome_pkg::SIZE_QWORD, 3'd3, 1'b0,
                                   xome_pkg::REG_SP, 1'b0, 0)};
      directed = {directed, mk_req(16'h008B, xome_pkg::SIZE_WORD,  3'd6, 1'b0,
                                   xome_pkg::REG_BP, 1'b0, 0)};
      // disp8 / disp32 edges
      directed = {directed, mk_req(16'h0001, xome_pkg::SIZE_BYTE,  3'd0, 1'b0, 3'd3,
                                   1'b0, 127)};
      directed = {directed, mk_req(16'h0002, xome_pkg::SIZE_WORD,  3'd7, 1'b0,
                                   xome_pkg::REG_SP, 1'b0, -128)};
      directed = {directed, mk_req(16'h0003, xome_pkg::SIZE_DWORD, 3'd4, 1'b0, 3'd6,
                                   1'b0, 128)};
      directed = {directed, mk_req(16'h0004, xome_pkg::SIZE_QWORD, 3'd2, 1'b0,
                                   xome_pkg::REG_BP, 1'b0, -129)};
      directed = {directed, mk_req(16'h0005, xome_pkg::SIZE_BYTE,  3'd1, 1'b0,
                                   xome_pkg::REG_BP, 1'b0, -1)};
      // longest (qword prefix, two-byte opcode, SIB, disp32), then a two-byte opcode with disp32
      directed = {directed, mk_req(16'hFFFE, xome_pkg::SIZE_QWORD, 3'd7, 1'b0,
                                   xome_pkg::REG_SP, 1'b0, 32'sh8000_0000)};
      directed = {directed, mk_req(16'h8000, xome_pkg::SIZE_WORD,  3'd0, 1'b0, 3'd1,
                                   1'b0, 32'sh7FFF_FFFF)};
      // label forms, base ignored (SP must not add a SIB)
      directed = {directed, mk_req(16'h008D, xome_pkg::SIZE_QWORD, 3'd0, 1'b0,
                                   xome_pkg::REG_SP, 1'b1, 0)};
      directed = {directed, mk_req(16'h0F00, xome_pkg::SIZE_DWORD, 3'd7, 1'b0,
                                   xome_pkg::REG_BP, 1'b1, -1)};
      directed = {directed, mk_req(16'hFFFF, xome_pkg::SIZE_QWORD, 3'd5, 1'b0, 3'd7,
                                   1'b1, 32'sh1234_5678)};
      directed = {directed, mk_req(16'h0000, xome_pkg::SIZE_BYTE,  3'd2, 1'b0, 3'd0,
                                   1'b1, 32'sh8000_0000)};
      n_directed = directed.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         issue(directed[i]);
      repeat (RANDOM_ITEMS)
         issue(rand_req());
      start <= 1'b0;

      // drain: all predicted bytes out, then a few quiet cycles for strays
      do @(posedge clock); while (bytes_pending != 0);
      repeat (12) @(posedge clock);

      $display("Sent %0d requests (%0d directed) in random bursts; checked %0d bytes,",
               reqs_sent, n_directed, bytes_checked);
      $display("%0d of them relocation starts.", reloc_bytes);
      if (fail_count == 0 && bytes_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
